FILE: sv/event_timer_min_queue_core_defines.svh
// Assertion helpers for the timer table RTL.
`ifndef EVENT_TIMER_MIN_QUEUE_CORE_DEFINES_SVH
`define EVENT_TIMER_MIN_QUEUE_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define EVTQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define EVTQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/evtq_pkg.sv
package evtq_pkg;

	localparam int SLOTS_DEF     = 32;
	localparam int TIME_BITS_DEF = 32;

	// request kind codes on the input channel
	localparam logic [1:0] KIND_ADD_REL = 2'd0;
	localparam logic [1:0] KIND_ADD_ABS = 2'd1;
	localparam logic [1:0] KIND_RUN     = 2'd2;
	localparam logic [1:0] KIND_QUERY   = 2'd3;

	typedef enum logic [1:0] {
		OP_ADD_REL,
		OP_ADD_ABS,
		OP_RUN,
		OP_QUERY
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_CLAMPED  = 2'd1,
		STAT_OVERFLOW = 2'd2,
		STAT_EMPTY    = 2'd3
	} stat_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] time_value;
		logic [15:0] event_tag;
	} req_t;

	typedef struct packed {
		stat_t       status;
		logic        fired;
		logic [5:0]  slot;
		logic [31:0] event_time;
		logic [15:0] tag_out;
		logic        last;
	} res_t;

endpackage

FILE: sv/evtq_if.sv
interface evtq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] time_value;
	logic [15:0] event_tag;

	modport source (output valid, kind, time_value, event_tag, input ready);
	modport sink (input valid, kind, time_value, event_tag, output ready);
endinterface

interface evtq_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        fired;
	logic [5:0]  slot;
	logic [31:0] event_time;
	logic [15:0] tag_out;
	logic        last;

	modport source (output valid, status, fired, slot, event_time, tag_out, last,
		input ready);
	modport sink (input valid, status, fired, slot, event_time, tag_out, last,
		output ready);
endinterface

FILE: sv/evtq_front.sv
module evtq_front (
	input  logic          clk,
	input  logic          arst_n,
	evtq_req_if.sink      req,
	output logic          q_valid,
	output evtq_pkg::req_t q_data,
	input  logic          q_pop
);
	import evtq_pkg::*;

	req_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	req_t       dec;
	logic       push;

	// classify the request kind
	always_comb begin
		dec.time_value = req.time_value;
		dec.event_tag  = req.event_tag;
		case (req.kind)
			KIND_ADD_REL: dec.op = OP_ADD_REL;
			KIND_ADD_ABS: dec.op = OP_ADD_ABS;
			KIND_RUN:     dec.op = OP_RUN;
			KIND_QUERY:   dec.op = OP_QUERY;
			default:      dec.op = OP_QUERY;
		endcase
	end

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_data    = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

FILE: sv/evtq_back.sv
`include "event_timer_min_queue_core_defines.svh"

module evtq_back #(
	parameter int SLOTS     = evtq_pkg::SLOTS_DEF,
	parameter int TIME_BITS = evtq_pkg::TIME_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  evtq_pkg::req_t q_data,
	output logic           q_pop,
	evtq_res_if.source     res
);
	import evtq_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int EW = 16 + TIME_BITS;

	typedef enum logic [1:0] {ST_IDLE, ST_ADD, ST_SCAN, ST_DECIDE} state_t;

	state_t               state_q;
	op_t                  op_q;
	logic [TIME_BITS-1:0] tv_q;
	logic [15:0]          tag_q;
	logic [TIME_BITS-1:0] now_q;
	logic [SLOTS-1:0]     used_q;

	logic [EW-1:0]        mem [SLOTS];
	logic [EW-1:0]        mem_rd_s1;
	logic                 rd_v_s1;
	logic                 rd_used_s1;
	logic [IW-1:0]        rd_idx_s1;
	logic [IW-1:0]        idx_q;
	logic                 issuing_q;

	logic                 found_q;
	logic [IW-1:0]        best_idx_q;
	logic [TIME_BITS-1:0] best_time_q;
	logic [15:0]          best_tag_q;

	res_t                 pend_q;
	logic                 pend_v_q;
	res_t                 res_q;
	logic                 out_v_q;

	logic                 can_emit;
	logic                 emit;
	logic                 free_found;
	logic [IW-1:0]        free_idx;
	logic [TIME_BITS:0]   sum_w;
	logic [TIME_BITS-1:0] add_time;
	stat_t                add_stat;
	logic                 fire;
	logic                 fire_go;
	logic                 mem_we;
	logic [TIME_BITS-1:0] rd_time;
	logic [15:0]          rd_tag;

	assign can_emit = !out_v_q || res.ready;
	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign rd_time  = mem_rd_s1[TIME_BITS-1:0];
	assign rd_tag   = mem_rd_s1[EW-1:TIME_BITS];

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	// saturate relative times, clamp absolute times in the past
	always_comb begin
		sum_w = {1'b0, tv_q} + {1'b0, now_q};
		if (op_q == OP_ADD_REL) begin
			add_time = sum_w[TIME_BITS] ? '1 : sum_w[TIME_BITS-1:0];
			add_stat = STAT_OK;
		end else if (tv_q < now_q) begin
			add_time = now_q;
			add_stat = STAT_CLAMPED;
		end else begin
			add_time = tv_q;
			add_stat = STAT_OK;
		end
	end

	assign fire    = (op_q == OP_RUN) && found_q && (best_time_q <= tv_q);
	assign fire_go = (state_q == ST_DECIDE) && fire && (!pend_v_q || can_emit);
	assign mem_we  = (state_q == ST_ADD) && can_emit && free_found;
	assign emit    = can_emit && ((state_q == ST_ADD) ||
		((state_q == ST_DECIDE) && (op_q == OP_QUERY || pend_v_q || !fire)));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[free_idx] <= {tag_q, add_time};
		end
		mem_rd_s1 <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_ADD_REL;
			tv_q        <= '0;
			tag_q       <= '0;
			now_q       <= '0;
			used_q      <= '0;
			rd_v_s1     <= 1'b0;
			rd_used_s1  <= 1'b0;
			rd_idx_s1   <= '0;
			idx_q       <= '0;
			issuing_q   <= 1'b0;
			found_q     <= 1'b0;
			best_idx_q  <= '0;
			best_time_q <= '0;
			best_tag_q  <= '0;
			pend_q      <= '0;
			pend_v_q    <= 1'b0;
			res_q       <= '0;
			out_v_q     <= 1'b0;
		end else begin
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (res.ready) begin
				out_v_q <= 1'b0;
			end
			rd_v_s1    <= (state_q == ST_SCAN) && issuing_q;
			rd_used_s1 <= used_q[idx_q];
			rd_idx_s1  <= idx_q;

			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						op_q      <= q_data.op;
						tv_q      <= q_data.time_value[TIME_BITS-1:0];
						tag_q     <= q_data.event_tag;
						idx_q     <= '0;
						issuing_q <= 1'b1;
						found_q   <= 1'b0;
						if (q_data.op == OP_ADD_REL || q_data.op == OP_ADD_ABS) begin
							state_q <= ST_ADD;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_ADD: begin
					if (can_emit) begin
						if (free_found) begin
							used_q[free_idx] <= 1'b1;
							res_q <= '{add_stat, 1'b0, 6'(free_idx), 32'(add_time),
								16'd0, 1'b1};
						end else begin
							res_q <= '{STAT_OVERFLOW, 1'b0, 6'd0, 32'd0, 16'd0, 1'b1};
						end
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					// issue one read a cycle, fold the registered data into the minimum
					if (issuing_q) begin
						if (idx_q == IW'(SLOTS - 1)) begin
							issuing_q <= 1'b0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
					if (rd_v_s1 && rd_used_s1 && (!found_q || rd_time < best_time_q)) begin
						found_q     <= 1'b1;
						best_idx_q  <= rd_idx_s1;
						best_time_q <= rd_time;
						best_tag_q  <= rd_tag;
					end
					if (!issuing_q && !rd_v_s1) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (op_q == OP_QUERY) begin
						if (can_emit) begin
							if (found_q) begin
								res_q <= '{STAT_OK, 1'b0, 6'(best_idx_q),
									32'(best_time_q), 16'd0, 1'b1};
							end else begin
								res_q <= '{STAT_EMPTY, 1'b0, 6'd0, 32'd0, 16'd0, 1'b1};
							end
							state_q <= ST_IDLE;
						end
					end else if (pend_v_q) begin
						// release the held firing once the next one is known
						if (can_emit) begin
							res_q <= '{pend_q.status, pend_q.fired, pend_q.slot,
								pend_q.event_time, pend_q.tag_out, !fire};
							if (!fire) begin
								pend_v_q <= 1'b0;
								state_q  <= ST_IDLE;
							end
						end
					end else if (!fire) begin
						if (can_emit) begin
							res_q   <= '{STAT_EMPTY, 1'b0, 6'd0, 32'd0, 16'd0, 1'b1};
							state_q <= ST_IDLE;
						end
					end
					if (fire_go) begin
						used_q[best_idx_q] <= 1'b0;
						now_q     <= best_time_q;
						pend_q    <= '{STAT_OK, 1'b1, 6'(best_idx_q), 32'(best_time_q),
							best_tag_q, 1'b0};
						pend_v_q  <= 1'b1;
						idx_q     <= '0;
						issuing_q <= 1'b1;
						found_q   <= 1'b0;
						state_q   <= ST_SCAN;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res.valid      = out_v_q;
	assign res.status     = res_q.status;
	assign res.fired      = res_q.fired;
	assign res.slot       = res_q.slot;
	assign res.event_time = res_q.event_time;
	assign res.tag_out    = res_q.tag_out;
	assign res.last       = res_q.last;

	`EVTQ_ASSERT_ALWAYS(a_pop_idle, q_pop |-> state_q == ST_IDLE, "pop outside idle")
	`EVTQ_ASSERT(a_now_mono, 1'b1 |=> now_q >= $past(now_q), "current time moved back")
	`EVTQ_ASSERT(a_fire_frees, fire_go |=> !used_q[$past(best_idx_q)], "fired slot not freed")
	`EVTQ_ASSERT(a_fired_ok, (out_v_q && res_q.fired) |-> res_q.status == STAT_OK,
		"fired result with bad status")
endmodule

FILE: sv/event_timer_min_queue_core.sv
// An add answers from ST_ADD once it leaves the queue; a query answers after a full scan
// of the slot memory in ST_SCAN, then ST_DECIDE; a run holds each firing until the next scan.
// Throughput: one request at a time in the back end, bounded by the one-entry-a-cycle
// slot memory scan; the front queue holds two more requests meanwhile.
// Reset: arst_n clears the slot used bits, the current time and all control state;
// slot times and tags stay undefined until written.
module event_timer_min_queue_core #(
	parameter int SLOTS     = evtq_pkg::SLOTS_DEF,
	parameter int TIME_BITS = evtq_pkg::TIME_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	evtq_req_if.sink   req,
	evtq_res_if.source res
);
	import evtq_pkg::*;

	logic q_valid;
	req_t q_data;
	logic q_pop;

	// front end: accept and classify requests, buffer them
	evtq_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop)
	);

	// back end: add, scan for the earliest event, fire, answer
	evtq_back #(
		.SLOTS     (SLOTS),
		.TIME_BITS (TIME_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.res     (res)
	);
endmodule

FILE: sim/event_timer_min_queue_core_checker.sv
`timescale 1ns / 100ps

module event_timer_min_queue_core_checker #(
	parameter int SLOTS = evtq_pkg::SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	evtq_req_if  req,
	evtq_res_if  res,
	output int   fail_count,
	output int   outstanding
);
	import evtq_pkg::*;

	localparam logic [31:0] TICK_MAX = 32'hFFFF_FFFF;

	bit          busy_slot [SLOTS];
	logic [31:0] slot_when [SLOTS];
	logic [15:0] slot_handle [SLOTS];
	logic [31:0] clock_now;
	int          mark;
	res_t        awaited [$];

	assign outstanding = awaited.size();

	function automatic int soonest_slot();
		int best;
		best = -1;
		for (int i = 0; i < mark; i++)
			if (busy_slot[i] && (best < 0 || slot_when[i] < slot_when[best]))
				best = i;
		return best;
	endfunction

	function automatic res_t make_res(stat_t st, logic f, int s, logic [31:0] t,
		logic [15:0] g, logic l);
		res_t r;
		r.status = st;
		r.fired = f;
		r.slot = 6'(s);
		r.event_time = t;
		r.tag_out = g;
		r.last = l;
		return r;
	endfunction

	task automatic schedule_event(logic [31:0] t, stat_t st, logic [15:0] g);
		int i;
		i = 0;
		while (i < mark && busy_slot[i])
			i++;
		if (i >= SLOTS) begin
			awaited.push_back(make_res(STAT_OVERFLOW, 0, 0, 0, 0, 1));
		end else begin
			busy_slot[i] = 1;
			slot_when[i] = t;
			slot_handle[i] = g;
			if (i + 1 > mark)
				mark = i + 1;
			awaited.push_back(make_res(st, 0, i, t, 0, 1));
		end
	endtask

	task automatic predict_request(op_t op, logic [31:0] tv, logic [15:0] g);
		logic [32:0] sum;
		int s, n;
		case (op)
			OP_ADD_REL: begin
				sum = {1'b0, tv} + {1'b0, clock_now};
				schedule_event(sum[32] ? TICK_MAX : sum[31:0], STAT_OK, g);
			end
			OP_ADD_ABS: begin
				if (tv < clock_now)
					schedule_event(clock_now, STAT_CLAMPED, g);
				else
					schedule_event(tv, STAT_OK, g);
			end
			OP_RUN: begin
				n = 0;
				forever begin
					s = soonest_slot();
					if (s < 0 || slot_when[s] > tv || n >= SLOTS)
						break;
					// advance time to the firing event and free its slot
					clock_now = slot_when[s];
					busy_slot[s] = 0;
					awaited.push_back(make_res(STAT_OK, 1, s, slot_when[s], slot_handle[s], 0));
					n++;
				end
				if (n == 0)
					awaited.push_back(make_res(STAT_EMPTY, 0, 0, 0, 0, 1));
				else
					awaited[$].last = 1;
			end
			default: begin
				s = soonest_slot();
				if (s < 0)
					awaited.push_back(make_res(STAT_EMPTY, 0, 0, 0, 0, 1));
				else
					awaited.push_back(make_res(STAT_OK, 0, s, slot_when[s], 0, 1));
			end
		endcase
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s got %0h want %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		clock_now = 0;
		mark = 0;
		foreach (busy_slot[i])
			busy_slot[i] = 0;
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (res.valid && res.ready) begin
				if (awaited.size() == 0) begin
					report("unexpected result, slot", res.slot, 0);
				end else begin
					want = awaited.pop_front();
					if (res.status !== want.status)
						report("status", res.status, want.status);
					if (res.fired !== want.fired)
						report("fired", res.fired, want.fired);
					if (res.slot !== want.slot)
						report("slot", res.slot, want.slot);
					if (res.event_time !== want.event_time)
						report("event_time", res.event_time, want.event_time);
					if (res.tag_out !== want.tag_out)
						report("tag_out", res.tag_out, want.tag_out);
					if (res.last !== want.last)
						report("last", res.last, want.last);
				end
			end
			if (req.valid && req.ready)
				predict_request(op_t'(req.kind), req.time_value, req.event_tag);
		end
	end
endmodule

FILE: sim/event_timer_min_queue_core_test.sv
`timescale 1ns / 100ps

module event_timer_min_queue_core_test;
	import evtq_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 400;

	logic clk = 0;
	logic arst_n = 0;
	int   fail_count, outstanding;
	int   quiet_cycles;
	bit   quiet_window = 0;   // both sides stop idling while set
	bit   hold_now = 0;       // tells the receiver to hold off
	logic [31:0] horizon;     // upper bound on the block's current time

	evtq_req_if req ();
	evtq_res_if res ();

	event_timer_min_queue_core dut (.clk(clk), .arst_n(arst_n), .req(req), .res(res));

	event_timer_min_queue_core_checker checker_i (.clk(clk), .arst_n(arst_n), .req(req),
		.res(res), .fail_count(fail_count), .outstanding(outstanding));

	always #1 clk = ~clk;

	function automatic bit take_break();
		return !quiet_window && $urandom_range(0, 99) < 11;
	endfunction

	// Offer one request; drop valid for random gaps first, then hold it until accepted.
	task automatic send_request(op_t op, logic [31:0] tv, logic [15:0] tag);
		@(negedge clk);
		while (take_break()) begin
			req.valid <= 0;
			@(negedge clk);
		end
		req.valid <= 1;
		req.kind <= op;
		req.time_value <= tv;
		req.event_tag <= tag;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
	endtask

	task automatic random_request();
		int pick;
		logic [31:0] tv;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			tv = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 60);
			send_request(OP_ADD_REL, tv, 16'($urandom));
		end else if (pick < 60) begin
			// mostly near the current time, so some land in the past and clamp
			tv = ($urandom_range(0, 9) == 0) ? $urandom
				: horizon + $urandom_range(0, 80) - $urandom_range(0, 30);
			send_request(OP_ADD_ABS, tv, 16'($urandom));
		end else if (pick < 85) begin
			horizon = horizon + $urandom_range(0, 50);
			send_request(OP_RUN, horizon, 16'($urandom));
		end else begin
			send_request(OP_QUERY, $urandom, 16'($urandom));
		end
	endtask

	// Receiver: random stalls, one long hold-off so the front queue fills.
	initial begin
		res.ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_now) begin
				res.ready <= 0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_now = 0;
			end
			res.ready <= !take_break();
		end
	end

	// Watchdog: count cycles with no handshake on either channel.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (res.valid && res.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		quiet_cycles = 0;
		horizon = 10;
		req.valid = 0;
		req.kind = OP_QUERY;
		req.time_value = 0;
		req.event_tag = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: empty table, ties, clamping, saturation
		send_request(OP_QUERY, 32'h0, 16'h0);
		send_request(OP_RUN, 32'd100, 16'h0);
		send_request(OP_ADD_REL, 32'h0, 16'h0);
		send_request(OP_ADD_ABS, 32'hFFFF_FFFF, 16'hFFFF);
		send_request(OP_ADD_REL, 32'd10, 16'hA5A5);
		send_request(OP_ADD_ABS, 32'd10, 16'h5A5A);
		send_request(OP_ADD_ABS, 32'd5, 16'h1234);
		send_request(OP_QUERY, 32'hFFFF_FFFF, 16'hFFFF);
		send_request(OP_RUN, 32'd10, 16'h0);
		send_request(OP_ADD_ABS, 32'd3, 16'h0F0F);
		send_request(OP_ADD_REL, 32'hFFFF_FFFF, 16'hF0F0);
		send_request(OP_ADD_REL, 32'hFFFF_FFF0, 16'h8001);
		send_request(OP_ADD_REL, 32'h0000_00FF, 16'h7FFE);
		send_request(OP_QUERY, 32'h0, 16'h0);
		send_request(OP_RUN, 32'd10, 16'h0);
		send_request(OP_RUN, 32'd9, 16'h0);

		for (int i = 0; i < 130; i++) begin
			if (i == 40)
				hold_now = 1;
			quiet_window = (i >= 90 && i < 120);
			if (i == 70) begin
				// fill the table past its end to hit overflow, then drain part of it
				repeat (34) send_request(OP_ADD_REL, $urandom_range(0, 40), 16'($urandom));
				horizon = horizon + 40;
				send_request(OP_RUN, horizon, 16'($urandom));
			end
			random_request();
		end
		quiet_window = 0;
		send_request(OP_RUN, 32'hFFFF_FFFF, 16'h0);
		send_request(OP_QUERY, 32'h0, 16'h0);
		@(negedge clk);
		req.valid <= 0;

		while (outstanding != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

FILE: event_timer_min_queue_core.f
+incdir+sv
sv/evtq_pkg.sv
sv/evtq_if.sv
sv/evtq_front.sv
sv/evtq_back.sv
sv/event_timer_min_queue_core.sv
sim/event_timer_min_queue_core_checker.sv
sim/event_timer_min_queue_core_test.sv
